// File: src/spi_pkg.sv
// Shared types and constants for the segment/plane intersection unit.
// No dependencies.
package spi_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIR_W   = 33;
  localparam int unsigned SUM_W   = 67;
  localparam int unsigned MAG_W   = 66;
  localparam int unsigned REM_W   = 66;
  localparam int unsigned QUOT_W  = 33;
  localparam int unsigned PROD_W  = 99;
  localparam int unsigned NCELL   = QUOT_W;
  localparam int unsigned IDX_W   = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_NORMAL_X = 3'd0,
    REG_NORMAL_Y = 3'd1,
    REG_NORMAL_Z = 3'd2,
    REG_OFFSET   = 3'd3,
    REG_EPSILON  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] s;
    logic                      dneg;
    logic [REM_W-1:0]          r;
    logic [QUOT_W-1:0]         w;
  } lane_t;

  typedef struct packed {
    logic             hit;
    logic             den_neg;
    logic [MAG_W-1:0] dm;
    lane_t [2:0]      lane;
  } cell_t;

endpackage

// File: src/spi_front.sv
// Front pipeline: direction, dot products, plane test and dividend products.
// Depends on spi_pkg; feeds the divider cell chain.
module spi_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic signed [spi_pkg::COORD_W-1:0]  start_x,
  input  logic signed [spi_pkg::COORD_W-1:0]  start_y,
  input  logic signed [spi_pkg::COORD_W-1:0]  start_z,
  input  logic signed [spi_pkg::COORD_W-1:0]  end_x,
  input  logic signed [spi_pkg::COORD_W-1:0]  end_y,
  input  logic signed [spi_pkg::COORD_W-1:0]  end_z,
  input  logic signed [spi_pkg::COORD_W-1:0]  normal [3],
  input  logic signed [spi_pkg::COORD_W-1:0]  plane_offset,
  input  logic [30:0]                         parallel_epsilon,
  output logic                                out_valid,
  output spi_pkg::cell_t                      out_data
);
  import spi_pkg::*;

  logic signed [COORD_W-1:0] st_in [3];
  logic signed [COORD_W-1:0] en_in [3];

  logic                      va, vb, vc, vd, ve;
  logic signed [COORD_W-1:0] s_a [3], s_b [3], s_c [3], s_d [3], s_e [3];
  logic signed [DIR_W-1:0]   d_a [3], d_b [3], d_c [3], d_d [3];
  logic signed [64:0]        pd_b [3];
  logic signed [63:0]        ps_b [3];
  logic signed [SUM_W-1:0]   den_c, num_c;
  logic [MAG_W-1:0]          dm_d, nm_d, dm_e;
  logic                      den_neg_d, num_neg_d, den_neg_e, hit_e;
  logic                      dneg_e [3];
  logic [64:0]               plo_e [3], phi_e [3];
  logic [MAG_W-1:0]          eps_sh;
  logic [31:0]               dabs [3];
  logic [PROD_W-1:0]         prod [3];
  logic                      hit_next;
  cell_t                     data_next;

  assign st_in[0] = start_x;
  assign st_in[1] = start_y;
  assign st_in[2] = start_z;
  assign en_in[0] = end_x;
  assign en_in[1] = end_y;
  assign en_in[2] = end_z;

  assign eps_sh = MAG_W'(parallel_epsilon) << FRAC_BITS;
  assign hit_next = (dm_d > eps_sh) && (nm_d != '0) && (num_neg_d == den_neg_d)
                    && (nm_d < dm_d);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dabs[i] = 32'(d_d[i][DIR_W-1] ? -d_d[i] : d_d[i]);
      prod[i] = PROD_W'(plo_e[i]) + (PROD_W'(phi_e[i]) << QUOT_W);
    end
    data_next.hit     = hit_e;
    data_next.den_neg = den_neg_e;
    data_next.dm      = dm_e;
    for (int i = 0; i < 3; i++) begin
      data_next.lane[i].s    = s_e[i];
      data_next.lane[i].dneg = dneg_e[i];
      data_next.lane[i].r    = prod[i][PROD_W-1:QUOT_W];
      data_next.lane[i].w    = prod[i][QUOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      out_valid <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s_a[i]  <= st_in[i];
        d_a[i]  <= DIR_W'(en_in[i]) - DIR_W'(st_in[i]);
        s_b[i]  <= s_a[i];
        d_b[i]  <= d_a[i];
        pd_b[i] <= d_a[i] * normal[i];
        ps_b[i] <= s_a[i] * normal[i];
        s_c[i]  <= s_b[i];
        d_c[i]  <= d_b[i];
        s_d[i]  <= s_c[i];
        d_d[i]  <= d_c[i];
        s_e[i]  <= s_d[i];
        dneg_e[i] <= d_d[i][DIR_W-1];
        plo_e[i]  <= 65'(dabs[i]) * 65'(nm_d[QUOT_W-1:0]);
        phi_e[i]  <= 65'(dabs[i]) * 65'(nm_d[MAG_W-1:QUOT_W]);
      end
      den_c <= SUM_W'(pd_b[0]) + SUM_W'(pd_b[1]) + SUM_W'(pd_b[2]);
      num_c <= (SUM_W'(plane_offset) <<< FRAC_BITS) - SUM_W'(ps_b[0])
               - SUM_W'(ps_b[1]) - SUM_W'(ps_b[2]);
      den_neg_d <= den_c[SUM_W-1];
      num_neg_d <= num_c[SUM_W-1];
      dm_d <= MAG_W'(den_c[SUM_W-1] ? -den_c : den_c);
      nm_d <= MAG_W'(num_c[SUM_W-1] ? -num_c : num_c);
      hit_e     <= hit_next;
      den_neg_e <= den_neg_d;
      dm_e      <= dm_d;
      out_data  <= data_next;
    end
  end

endmodule

// File: src/spi_div_cell.sv
// One restoring-division cell: one quotient bit per lane per request.
// Depends on spi_pkg; chained by the top level.
module spi_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  spi_pkg::cell_t in_data,
  output logic           out_valid,
  output spi_pkg::cell_t out_data
);
  import spi_pkg::*;

  logic [REM_W:0] trial [3];
  logic           ge [3];
  cell_t          data_next;

  always_comb begin
    data_next = in_data;
    for (int i = 0; i < 3; i++) begin
      trial[i] = {in_data.lane[i].r, in_data.lane[i].w[QUOT_W-1]};
      ge[i]    = trial[i] >= {1'b0, in_data.dm};
      data_next.lane[i].r = ge[i] ? REM_W'(trial[i] - {1'b0, in_data.dm})
                                  : trial[i][REM_W-1:0];
      data_next.lane[i].w = {in_data.lane[i].w[QUOT_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= data_next;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hit |->
      out_data.lane[0].r < out_data.dm && out_data.lane[1].r < out_data.dm &&
      out_data.lane[2].r < out_data.dm)
    else $error("division remainder not below divisor");

endmodule

// File: src/segment_plane_intersection_unit.sv
// Top level: config registers, front pipeline, divider cell chain, output register.
// Depends on spi_pkg, spi_front and spi_div_cell.
//
//  channel | direction | handshake          | contents
//  in      | request   | in_valid/in_stall  | start_x..z, end_x..z
//  out     | result    | out_valid/out_stall| hit, point_x..z, facing_x..z
//  cfg     | write     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request per cycle unless a stalled result holds the pipeline; 6 front stages, one divider cell
// per quotient bit (33), one output register.
// Reset empties the pipeline and loads the default plane (normal +y, offset 0).
// A stalled result holds the whole pipeline; in_stall follows it.
module segment_plane_intersection_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [spi_pkg::COORD_W-1:0] start_x,
  input  logic signed [spi_pkg::COORD_W-1:0] start_y,
  input  logic signed [spi_pkg::COORD_W-1:0] start_z,
  input  logic signed [spi_pkg::COORD_W-1:0] end_x,
  input  logic signed [spi_pkg::COORD_W-1:0] end_y,
  input  logic signed [spi_pkg::COORD_W-1:0] end_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hit,
  output logic signed [spi_pkg::COORD_W-1:0] point_x,
  output logic signed [spi_pkg::COORD_W-1:0] point_y,
  output logic signed [spi_pkg::COORD_W-1:0] point_z,
  output logic signed [spi_pkg::COORD_W-1:0] facing_x,
  output logic signed [spi_pkg::COORD_W-1:0] facing_y,
  output logic signed [spi_pkg::COORD_W-1:0] facing_z,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spi_pkg::IDX_W-1:0]          cfg_index,
  input  logic [spi_pkg::COORD_W-1:0]        cfg_data
);
  import spi_pkg::*;

  localparam logic signed [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;
  localparam logic signed [COORD_W-1:0] MAXV = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] MINV = {1'b1, {(COORD_W-1){1'b0}}};

  logic signed [COORD_W-1:0] normal [3];
  logic signed [COORD_W-1:0] plane_offset;
  logic [30:0]               parallel_epsilon;
  logic                      adv;

  logic  chain_v [NCELL+1];
  cell_t chain_d [NCELL+1];

  logic signed [COORD_W+2:0] psum [3];
  logic signed [COORD_W-1:0] pclamp [3];
  logic signed [COORD_W-1:0] face [3];
  logic signed [COORD_W-1:0] point_r [3];
  logic signed [COORD_W-1:0] facing_r [3];

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal[0]        <= '0;
      normal[1]        <= ONE;
      normal[2]        <= '0;
      plane_offset     <= '0;
      parallel_epsilon <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NORMAL_X: normal[0]        <= cfg_data;
        REG_NORMAL_Y: normal[1]        <= cfg_data;
        REG_NORMAL_Z: normal[2]        <= cfg_data;
        REG_OFFSET:   plane_offset     <= cfg_data;
        REG_EPSILON:  parallel_epsilon <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  spi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .adv, .in_valid,
    .start_x, .start_y, .start_z, .end_x, .end_y, .end_z,
    .normal, .plane_offset, .parallel_epsilon,
    .out_valid (chain_v[0]),
    .out_data  (chain_d[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    spi_div_cell u_cell (
      .clk, .rst, .adv,
      .in_valid  (chain_v[g]),
      .in_data   (chain_d[g]),
      .out_valid (chain_v[g+1]),
      .out_data  (chain_d[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = chain_d[NCELL].lane[i].dneg
              ? (COORD_W+3)'(chain_d[NCELL].lane[i].s)
                - signed'({2'b00, chain_d[NCELL].lane[i].w})
              : (COORD_W+3)'(chain_d[NCELL].lane[i].s)
                + signed'({2'b00, chain_d[NCELL].lane[i].w});
      if (psum[i] > (COORD_W+3)'(MAXV)) pclamp[i] = MAXV;
      else if (psum[i] < (COORD_W+3)'(MINV)) pclamp[i] = MINV;
      else pclamp[i] = psum[i][COORD_W-1:0];
      if (chain_d[NCELL].den_neg) face[i] = normal[i];
      else if (normal[i] == MINV) face[i] = MAXV;
      else face[i] = -normal[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= chain_v[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= chain_d[NCELL].hit;
      for (int i = 0; i < 3; i++) begin
        point_r[i]  <= chain_d[NCELL].hit ? pclamp[i] : '0;
        facing_r[i] <= chain_d[NCELL].hit ? face[i] : '0;
      end
    end
  end

  assign point_x  = point_r[0];
  assign point_y  = point_r[1];
  assign point_z  = point_r[2];
  assign facing_x = facing_r[0];
  assign facing_y = facing_r[1];
  assign facing_z = facing_r[2];

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |->
      point_x == '0 && point_y == '0 && point_z == '0 &&
      facing_x == '0 && facing_y == '0 && facing_z == '0)
    else $error("miss result not zero");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !chain_v[NCELL])
    else $error("pipeline not empty after reset");

endmodule
